### sv/rtt_pkg.sv
// shared types and constants of the repeating timer table
`default_nettype none

package rtt_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

	typedef logic [SLOT_W-1:0] slot_idx_t;

	typedef enum logic [1:0] {
		KIND_ADD  = 2'd0,
		KIND_DEL  = 2'd1,
		KIND_TICK = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_DELETED   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_FIRED     = 3'd4,
		ST_NEXT_DUE  = 3'd5,
		ST_NONE      = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] ident;
		logic [31:0] deadline;
		logic [31:0] period;
		logic [31:0] repeats;
	} entry_t;

	// per-slot verdict of the scan unit
	typedef struct packed {
		logic        fire;
		logic        keep;
		logic        wr;
		logic        match;
		logic        any;
		logic [31:0] earliest;
		entry_t      entry;
	} exec_res_t;

endpackage

`default_nettype wire

### sv/rtt_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module rtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/rtt_exec.sv
// scan unit: expiry, rearm, repeat countdown, id match and earliest deadline of one slot
`default_nettype none

module rtt_exec (
	input  wire logic              tick_mode,
	input  wire logic              slot_valid,
	input  wire rtt_pkg::entry_t   entry,
	input  wire logic [31:0]       now,
	input  wire logic [31:0]       target,
	input  wire logic [31:0]       earliest,
	input  wire logic              any,
	output rtt_pkg::exec_res_t     res
);
	import rtt_pkg::*;

	logic        expired;
	logic        retire;
	logic [31:0] rep_n;
	logic [31:0] rearm;
	logic [31:0] cand;

	always_comb begin
		expired = slot_valid && (entry.deadline <= now);
		rearm   = now + entry.period;
		rep_n   = (entry.repeats != 32'd0) ? entry.repeats - 32'd1 : 32'd0;
		// unlimited timers never retire
		retire  = expired && (entry.repeats != 32'd0) && (rep_n == 32'd0);
		cand    = expired ? rearm : entry.deadline;

		res.entry          = entry;
		res.entry.deadline = rearm;
		res.entry.repeats  = rep_n;
		res.match          = 1'b0;
		res.fire           = 1'b0;
		res.wr             = 1'b0;
		res.keep           = slot_valid;
		res.any            = any;
		res.earliest       = earliest;

		if (tick_mode) begin
			res.fire = expired;
			res.wr   = expired && !retire;
			res.keep = slot_valid && !retire;
			if (res.keep) begin
				res.any = 1'b1;
				if (!any || (cand < earliest)) begin
					res.earliest = cand;
				end
			end
		end else begin
			res.match = slot_valid && (entry.ident == target);
			res.keep  = slot_valid && !res.match;
		end
	end

endmodule

`default_nettype wire

### sv/repeating_timer_table.sv
// top level of the repeating timer table: sequencer, slot valid bits and result register
`default_nettype none

// A flat table of SLOTS repeating timers. An add transfer answers with the new
// id or table full. A delete or a tick transfer walks the entry ram one slot per
// cycle through the shared scan unit, while the result side has room for its
// fired results. Each tick yields one fired result per expired timer and ends
// with a next-due or none-active result marked by tlast. No new item is taken
// while a scan is in progress.
module repeating_timer_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [95:0] s_axis_tdata,  // interval_ms, repeat_count, target_id
	input  wire logic [1:0]  s_axis_tuser,  // kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // timer_ident, ms_to_next
	output logic [2:0]       m_axis_tuser,  // status
	output logic             m_axis_tlast
);
	import rtt_pkg::*;

	state_t          state_q, state_d;
	slot_idx_t       idx_q;
	logic [31:0]     now_q;
	logic [31:0]     next_ident_q;
	logic [SLOTS-1:0] valid_q;
	logic [31:0]     earliest_q;
	logic            any_q;
	logic            found_q;
	logic [31:0]     target_q;
	logic            tick_mode_q;

	logic            out_valid_q;
	status_t         out_status_q;
	logic [31:0]     out_ident_q;
	logic [31:0]     out_ms_q;
	logic            out_last_q;

	kind_t           in_kind;
	logic [31:0]     in_interval;
	logic [31:0]     in_repeats;
	logic [31:0]     in_target;
	logic            accept_in;
	logic            out_free;

	logic            free_any;
	slot_idx_t       free_idx;

	logic            ram_we;
	slot_idx_t       ram_waddr;
	entry_t          ram_wdata;
	logic            ram_re;
	slot_idx_t       ram_raddr;
	logic [$bits(entry_t)-1:0] ram_rdata;

	exec_res_t       res;
	logic            advance;

	logic            out_load;
	status_t         out_status_d;
	logic [31:0]     out_ident_d;
	logic [31:0]     out_ms_d;
	logic            out_last_d;

	assign in_kind     = kind_t'(s_axis_tuser);
	assign in_interval = s_axis_tdata[31:0];
	assign in_repeats  = s_axis_tdata[63:32];
	assign in_target   = s_axis_tdata[95:64];

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	assign accept_in     = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_ms_q, out_ident_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

	// lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	rtt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(SLOTS)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	rtt_exec u_exec (
		.tick_mode (tick_mode_q),
		.slot_valid(valid_q[idx_q]),
		.entry     (entry_t'(ram_rdata)),
		.now       (now_q),
		.target    (target_q),
		.earliest  (earliest_q),
		.any       (any_q),
		.res       (res)
	);

	// a fired result waits for room in the result register
	assign advance = !(res.fire && !out_free);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept_in && (in_kind == KIND_DEL || in_kind == KIND_TICK)) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (advance && idx_q == LAST_SLOT) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ram_we       = 1'b0;
		ram_waddr    = idx_q;
		ram_wdata    = res.entry;
		ram_re       = 1'b0;
		ram_raddr    = '0;
		out_load     = 1'b0;
		out_status_d = ST_NONE;
		out_ident_d  = '0;
		out_ms_d     = '0;
		out_last_d   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (accept_in) begin
					unique case (in_kind)
						KIND_ADD: begin
							out_load = 1'b1;
							if (free_any) begin
								ram_we       = 1'b1;
								ram_waddr    = free_idx;
								ram_wdata    = '{ident: next_ident_q,
								                 deadline: now_q + in_interval,
								                 period: in_interval,
								                 repeats: in_repeats};
								out_status_d = ST_ADDED;
								out_ident_d  = next_ident_q;
							end else begin
								out_status_d = ST_FULL;
							end
						end
						KIND_DEL, KIND_TICK: begin
							ram_re    = 1'b1;
							ram_raddr = '0;
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				if (advance) begin
					ram_we = res.wr;
					if (res.fire) begin
						out_load     = 1'b1;
						out_status_d = ST_FIRED;
						out_ident_d  = res.entry.ident;
						out_last_d   = 1'b0;
					end
					if (idx_q != LAST_SLOT) begin
						ram_re    = 1'b1;
						ram_raddr = idx_q + 1'b1;
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					if (tick_mode_q) begin
						if (any_q) begin
							out_status_d = ST_NEXT_DUE;
							out_ms_d     = (earliest_q > now_q) ? earliest_q - now_q : 32'd0;
						end else begin
							out_status_d = ST_NONE;
						end
					end else begin
						out_status_d = found_q ? ST_DELETED : ST_NOT_FOUND;
						out_ident_d  = target_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			now_q        <= '0;
			next_ident_q <= '0;
			valid_q      <= '0;
			earliest_q   <= '0;
			any_q        <= 1'b0;
			found_q      <= 1'b0;
			target_q     <= '0;
			tick_mode_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept_in) begin
						idx_q <= '0;
						unique case (in_kind)
							KIND_ADD: begin
								if (free_any) begin
									valid_q[free_idx] <= 1'b1;
									next_ident_q      <= next_ident_q + 32'd1;
								end
							end
							KIND_DEL: begin
								tick_mode_q <= 1'b0;
								target_q    <= in_target;
								found_q     <= 1'b0;
							end
							KIND_TICK: begin
								tick_mode_q <= 1'b1;
								now_q       <= now_q + 32'd1;
								any_q       <= 1'b0;
								earliest_q  <= '1;
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (advance) begin
						valid_q[idx_q] <= res.keep;
						earliest_q     <= res.earliest;
						any_q          <= res.any;
						found_q        <= found_q || res.match;
						if (idx_q != LAST_SLOT) begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_DONE: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= out_status_d;
			out_ident_q  <= out_ident_d;
			out_ms_q     <= out_ms_d;
			out_last_q   <= out_last_d;
		end
	end

`ifndef SYNTHESIS
	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == S_IDLE)
		else $error("input taken while a scan is in progress");

	a_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == ST_FIRED) |-> !m_axis_tlast)
		else $error("fired result marked as final");

	a_one_add_per_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) <= $countones($past(valid_q)) + 1)
		else $error("more than one slot armed in a cycle");

	a_tick_advances_clock: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_in && in_kind == KIND_TICK) |=> now_q == $past(now_q) + 32'd1)
		else $error("tick did not advance the millisecond count");

	a_scan_writes_current: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && ram_we) |-> (ram_waddr == idx_q && tick_mode_q))
		else $error("scan wrote a slot other than the one under test");
`endif

endmodule

`default_nettype wire
